>>> sv/matrix_multiply_assert.svh
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("matrix_multiply assertion failed");

// Next-cycle implication.
`define MM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("matrix_multiply assertion failed");

`endif

>>> sv/mm_pkg.sv
package mm_pkg;

  localparam int DIM       = 8;
  localparam int IDX_W     = $clog2(DIM);
  localparam int SIZE_W    = 4;
  localparam int VAL_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCORRECT  = 2'd1,
    ST_CALC_ERROR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 3'd0,
    REG_A_COLS = 3'd1,
    REG_B_ROWS = 3'd2,
    REG_B_COLS = 3'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_WAIT,
    S_DRAIN,
    S_ERR
  } state_e;

  typedef struct packed {
    logic clr;
    logic prod_en;
    logic mac;
    logic shift;
  } cell_ctrl_t;

  // Drop the fraction bits (floor) and clamp to the 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat_fix(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    r  = s >>> FRAC_BITS;
    hi = $signed({{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
    lo = $signed({{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
    if (r > hi) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (r < lo) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end
    return r[VAL_W-1:0];
  endfunction

endpackage

>>> sv/mm_cell.sv
module mm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mm_pkg::cell_ctrl_t         ctrl_i,
  input  logic signed [31:0]         a_i,
  input  logic signed [31:0]         b_i,
  input  logic signed [mm_pkg::ACC_W-1:0] acc_i,
  output logic signed [mm_pkg::ACC_W-1:0] acc_o
);
  import mm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= a_i * b_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.mac) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end else if (ctrl_i.shift) begin
      acc_d = acc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule

>>> sv/matrix_multiply.sv
// Fixed-point (Q16.16) matrix multiplier. Commands on the input stream load
// one element of A or B per cycle; a run multiplies the a_rows x a_cols part
// of A by the b_rows x b_cols part of B and streams the product out row-major,
// tlast on the final element. A row of DIM cells holds the accumulators of
// one product row: each cycle one A element is broadcast against one B row,
// and the finished row is then shifted out through the cells to the output.
// A zero size or a_cols != b_rows gives a single error result. No input is
// taken while a run is in progress.
module matrix_multiply (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // row[2:0], col[5:3], value[37:6], zero[39:38]
  input  logic [1:0]  s_tuser_i,   // command[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // out_row[2:0], out_col[5:3], product[37:6], zero[39:38]
  output logic [1:0]  m_tuser_o,   // status[1:0]
  output logic        m_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  import mm_pkg::*;

  state_e state_q, state_d;
  logic [SIZE_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [SIZE_W-1:0] ar, ac, br, bc;
  logic [SIZE_W-1:0] i_q, i_d, k_q, k_d, j_q, j_d;
  logic rd_v_q, pr_v_q;
  logic signed [VAL_W-1:0] a_val_q;
  logic [VAL_W-1:0] a_mem_q [DIM*DIM];
  logic signed [ACC_W-1:0] acc_w [DIM];

  logic in_acc, out_free, issue, clr, load_ok, load_err;
  status_e err_q, err_d;
  cell_ctrl_t ctrl;

  logic [1:0]       in_cmd;
  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_val;

  logic                    out_valid_q, out_last_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic [VAL_W-1:0]        out_prod_q;
  status_e                 out_status_q;

  assign in_cmd = s_tuser_i;
  assign in_row = s_tdata_i[2:0];
  assign in_col = s_tdata_i[5:3];
  assign in_val = s_tdata_i[37:6];

  assign ar = (a_rows_q > SIZE_W'(DIM)) ? SIZE_W'(DIM) : a_rows_q;
  assign ac = (a_cols_q > SIZE_W'(DIM)) ? SIZE_W'(DIM) : a_cols_q;
  assign br = (b_rows_q > SIZE_W'(DIM)) ? SIZE_W'(DIM) : b_rows_q;
  assign bc = (b_cols_q > SIZE_W'(DIM)) ? SIZE_W'(DIM) : b_cols_q;

  assign s_tready_o  = (state_q == S_IDLE);
  assign in_acc      = s_tvalid_i && s_tready_o;
  assign out_free    = !out_valid_q || m_tready_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= SIZE_RESET;
      a_cols_q <= SIZE_RESET;
      b_rows_q <= SIZE_RESET;
      b_cols_q <= SIZE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_A_ROWS: a_rows_q <= cfg_data_i;
        REG_A_COLS: a_cols_q <= cfg_data_i;
        REG_B_ROWS: b_rows_q <= cfg_data_i;
        REG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    k_d      = k_q;
    j_d      = j_q;
    err_d    = err_q;
    issue    = 1'b0;
    clr      = 1'b0;
    load_ok  = 1'b0;
    load_err = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_RUN) begin
          if (ar == '0 || ac == '0 || br == '0 || bc == '0) begin
            err_d   = ST_INCORRECT;
            state_d = S_ERR;
          end else if (ac != br) begin
            err_d   = ST_CALC_ERROR;
            state_d = S_ERR;
          end else begin
            i_d     = '0;
            k_d     = '0;
            state_d = S_MAC;
          end
        end
      end
      S_MAC: begin
        issue = 1'b1;
        clr   = (k_q == '0);
        k_d   = k_q + 1'b1;
        if (k_q == ac - 1'b1) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!rd_v_q && !pr_v_q) begin
          j_d     = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          load_ok = 1'b1;
          j_d     = j_q + 1'b1;
          if (j_q == bc - 1'b1) begin
            if (i_q == ar - 1'b1) begin
              state_d = S_IDLE;
            end else begin
              i_d     = i_q + 1'b1;
              k_d     = '0;
              state_d = S_MAC;
            end
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          load_err = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      err_q   <= ST_OK;
      rd_v_q  <= 1'b0;
      pr_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      j_q     <= j_d;
      err_q   <= err_d;
      rd_v_q  <= issue;
      pr_v_q  <= rd_v_q;
    end
  end

  // Store for A; B is kept column by column in banks beside the cells.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == CMD_LOAD_A) begin
      a_mem_q[{in_row, in_col}] <= in_val;
    end
    if (issue) begin
      a_val_q <= a_mem_q[{i_q[IDX_W-1:0], k_q[IDX_W-1:0]}];
    end
  end

  assign ctrl.clr     = clr;
  assign ctrl.prod_en = rd_v_q;
  assign ctrl.mac     = pr_v_q;
  assign ctrl.shift   = load_ok;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    logic [VAL_W-1:0]        b_bank_q [DIM];
    logic signed [VAL_W-1:0] b_val_q;
    logic signed [ACC_W-1:0] nbr;

    always_ff @(posedge clk_i) begin
      if (in_acc && in_cmd == CMD_LOAD_B && in_col == IDX_W'(c)) begin
        b_bank_q[in_row] <= in_val;
      end
      if (issue) begin
        b_val_q <= b_bank_q[k_q[IDX_W-1:0]];
      end
    end

    if (c == DIM - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = acc_w[c+1];
    end
    mm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .a_i    (a_val_q),
      .b_i    (b_val_q),
      .acc_i  (nbr),
      .acc_o  (acc_w[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok || load_err) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      out_row_q    <= i_q[IDX_W-1:0];
      out_col_q    <= j_q[IDX_W-1:0];
      out_prod_q   <= sat_fix(acc_w[0]);
      out_status_q <= ST_OK;
      out_last_q   <= (i_q == ar - 1'b1) && (j_q == bc - 1'b1);
    end else if (load_err) begin
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_prod_q   <= '0;
      out_status_q <= err_q;
      out_last_q   <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {2'b00, out_prod_q, out_col_q, out_row_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;
endmodule

>>> sv/mm_checker.sv
`include "matrix_multiply_assert.svh"

module mm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_o,
  input logic [1:0]  m_tuser_o,
  input logic        m_tlast_o
);
  import mm_pkg::*;

  logic err_out;
  logic status_ok;
  assign err_out   = m_tvalid_o && (m_tuser_o != ST_OK);
  assign status_ok = (m_tuser_o == ST_OK) || (m_tuser_o == ST_INCORRECT) ||
                     (m_tuser_o == ST_CALC_ERROR);

  // A waiting result is not withdrawn.
  `MM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i, m_tvalid_o)
  // An error result is a lone, final, all-zero result.
  `MM_ASSERT_IMP(a_err_shape, clk_i, rst_ni, err_out, m_tlast_o && m_tdata_o == '0)
  // The status is never the unused code.
  `MM_ASSERT_IMP(a_status_code, clk_i, rst_ni, m_tvalid_o, status_ok)
  // No request is taken while a run still has results to give.
  `MM_ASSERT_IMP(a_run_busy, clk_i, rst_ni, m_tvalid_o && !m_tlast_o, !s_tready_o)
endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);
